// File: rtl/fri_pkg.sv
// ----------------------------------------------------------------------------
// fri_pkg
// shared types, constants and helpers for the four register interpreter core
// ----------------------------------------------------------------------------
package fri_pkg;

  localparam int PROGRAM_DEPTH = 128;
  localparam int IP_W          = 7;
  localparam int LEN_W         = 8;
  localparam int DATA_W        = 16;
  localparam int SUM_W         = DATA_W + 2;
  localparam int DIV_STEPS     = DATA_W;
  localparam int CNT_W         = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ACT_MOV   = 4'd0,
    ACT_ADD   = 4'd1,
    ACT_SUB   = 4'd2,
    ACT_MUL   = 4'd3,
    ACT_DIV   = 4'd4,
    ACT_JMP   = 4'd5,
    ACT_JE    = 4'd6,
    ACT_JNE   = 4'd7,
    ACT_JG    = 4'd8,
    ACT_JGE   = 4'd9,
    ACT_JL    = 4'd10,
    ACT_JLE   = 4'd11,
    ACT_READ  = 4'd12,
    ACT_PRINT = 4'd13,
    ACT_NOP   = 4'd14
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DIVFIX,
    ST_DONE
  } state_e;

  function automatic logic past_end(logic [LEN_W-1:0] ip, logic [LEN_W-1:0] len);
    return (ip >= len) || (ip >= LEN_W'(PROGRAM_DEPTH));
  endfunction

  function automatic logic [SUM_W-1:0] sext(logic [DATA_W-1:0] v);
    return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

// File: rtl/four_register_interpreter_core.sv
// ----------------------------------------------------------------------------
// four_register_interpreter_core
// executes one decoded instruction per item on four 16-bit registers,
// with one shared 18-bit adder used for add, sub, compares and division
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  in       | in_valid_i / in_ready_o  | action_i .. read_value_i
//  out      | out_valid_o / out_ready_i| next_ip_o .. div_zero_o
//  cfg      | cfg_valid_i / cfg_ready_o| program_length_i
//
//  the result is valid after the execute state; a div with nonzero divisor goes from
//  execute through 16 restoring steps on the shared adder and a sign fix state first
//  a new item is taken only after out_ready_i has taken the last result
//  one item at a time: in_ready_o is high only when none is in flight
//  the result is held in output registers until out_ready_i takes it
//  reset clears registers, ip, halt flag and program length at once
// ----------------------------------------------------------------------------
module four_register_interpreter_core
  import fri_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [LEN_W-1:0]         program_length_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [3:0]               action_i,
  input  logic                     src_is_imm_i,
  input  logic [1:0]               src_reg_i,
  input  logic signed [DATA_W-1:0] src_imm_i,
  input  logic                     dst_is_imm_i,
  input  logic [1:0]               dst_reg_i,
  input  logic signed [DATA_W-1:0] dst_imm_i,
  input  logic [IP_W-1:0]          jump_target_i,
  input  logic signed [DATA_W-1:0] read_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IP_W-1:0]          next_ip_o,
  output logic                     halted_o,
  output logic                     print_valid_o,
  output logic signed [DATA_W-1:0] print_value_o,
  output logic                     div_zero_o
);

  state_e state_q, state_d;

  logic [LEN_W-1:0]  prog_len_q;
  logic [IP_W-1:0]   ip_q, ip_d;
  logic              halt_q, halt_d;

  logic [DATA_W-1:0] rf_mem [4];
  logic [3:0]        rf_vld_q;
  logic              rf_we;
  logic [DATA_W-1:0] rf_wdata;

  action_e           act_q;
  logic              src_is_imm_q, dst_is_imm_q;
  logic [1:0]        dst_reg_q;
  logic [DATA_W-1:0] src_imm_q, dst_imm_q, rd_val_q, src_rd_q, dst_rd_q;
  logic [IP_W-1:0]   tgt_q;

  logic [DATA_W-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [IP_W-1:0]   nip_q, nip_d;
  logic              hlt_q, hlt_d, pv_q, pv_d, dz_q, dz_d;
  logic [DATA_W-1:0] pval_q, pval_d;

  logic [SUM_W-1:0]  add_a, add_b, sum;
  logic              add_sub;

  logic [DATA_W-1:0] src, dval, opnd2, src_abs, dval_abs;
  logic [DATA_W-1:0] prod;
  logic [DATA_W:0]   shifted;
  logic              stop, lt, eq, jump, retire, div_go;
  logic [LEN_W-1:0]  nxt;

  logic in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  assign src      = src_is_imm_q ? src_imm_q : src_rd_q;
  assign dval     = dst_rd_q;
  assign opnd2    = dst_is_imm_q ? dst_imm_q : dval;
  assign src_abs  = src[DATA_W-1] ? DATA_W'(-src) : src;
  assign dval_abs = dval[DATA_W-1] ? DATA_W'(-dval) : dval;
  assign prod     = dval * src;
  assign shifted  = {rem_q, quo_q[DATA_W-1]};
  assign stop     = halt_q || past_end({1'b0, ip_q}, prog_len_q);
  assign div_go   = !stop && (act_q == ACT_DIV) && (dval != '0);

  // shared adder
  assign sum = add_sub ? (add_a - add_b) : (add_a + add_b);
  assign lt  = sum[SUM_W-1];
  assign eq  = (sum == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_EXEC;
      ST_EXEC:   state_d = div_go ? ST_DIV : ST_DONE;
      ST_DIV:    if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_DIVFIX;
      ST_DIVFIX: state_d = ST_DONE;
      ST_DONE:   if (out_fire) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_DONE);
    cfg_ready_o = 1'b1;
  end

  // datapath control
  always_comb begin
    add_a    = sext(dval);
    add_b    = sext(src);
    add_sub  = 1'b0;
    rf_we    = 1'b0;
    rf_wdata = src;
    jump     = 1'b0;
    retire   = 1'b0;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dvs_d    = dvs_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    ip_d     = ip_q;
    halt_d   = halt_q;
    nip_d    = nip_q;
    hlt_d    = hlt_q;
    pv_d     = pv_q;
    pval_d   = pval_q;
    dz_d     = dz_q;
    nxt      = '0;

    unique case (state_q)
      ST_EXEC: begin
        pv_d   = 1'b0;
        pval_d = '0;
        dz_d   = 1'b0;
        if (stop) begin
          halt_d = 1'b1;
          nip_d  = ip_q;
          hlt_d  = 1'b1;
        end else begin
          retire = 1'b1;
          case (act_q) inside
            ACT_MOV: rf_we = 1'b1;
            ACT_ADD: begin
              rf_we    = 1'b1;
              rf_wdata = sum[DATA_W-1:0];
            end
            ACT_SUB: begin
              add_sub  = 1'b1;
              rf_we    = 1'b1;
              rf_wdata = sum[DATA_W-1:0];
            end
            ACT_MUL: begin
              rf_we    = 1'b1;
              rf_wdata = prod;
            end
            ACT_DIV: begin
              if (dval == '0) begin
                rf_we    = 1'b1;
                rf_wdata = '0;
                dz_d     = 1'b1;
              end else begin
                retire = 1'b0;
                rem_d  = '0;
                quo_d  = src_abs;
                dvs_d  = dval_abs;
                neg_d  = src[DATA_W-1] ^ dval[DATA_W-1];
                cnt_d  = '0;
              end
            end
            ACT_JMP: jump = 1'b1;
            ACT_JE, ACT_JNE, ACT_JG, ACT_JGE, ACT_JL, ACT_JLE: begin
              add_a   = sext(src);
              add_b   = sext(opnd2);
              add_sub = 1'b1;
              case (act_q)
                ACT_JE:  jump = eq;
                ACT_JNE: jump = !eq;
                ACT_JG:  jump = !lt && !eq;
                ACT_JGE: jump = !lt;
                ACT_JL:  jump = lt;
                default: jump = lt || eq;
              endcase
            end
            ACT_READ: begin
              rf_we    = 1'b1;
              rf_wdata = rd_val_q;
            end
            ACT_PRINT: begin
              pv_d   = 1'b1;
              pval_d = src;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        add_a   = {1'b0, shifted};
        add_b   = {2'b00, dvs_q};
        add_sub = 1'b1;
        cnt_d   = cnt_q + CNT_W'(1);
        if (!sum[SUM_W-1]) begin
          rem_d = sum[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = shifted[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b0};
        end
      end
      ST_DIVFIX: begin
        add_a    = '0;
        add_b    = {2'b00, quo_q};
        add_sub  = neg_q;
        rf_we    = 1'b1;
        rf_wdata = sum[DATA_W-1:0];
        retire   = 1'b1;
      end
      default: ;
    endcase

    if (retire) begin
      nxt    = jump ? {1'b0, tgt_q} : ({1'b0, ip_q} + LEN_W'(1));
      halt_d = past_end(nxt, prog_len_q);
      ip_d   = nxt[IP_W-1:0];
      nip_d  = nxt[IP_W-1:0];
      hlt_d  = halt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      prog_len_q <= '0;
      ip_q       <= '0;
      halt_q     <= 1'b0;
      rf_vld_q   <= '0;
    end else begin
      state_q <= state_d;
      ip_q    <= ip_d;
      halt_q  <= halt_d;
      if (cfg_valid_i && cfg_ready_o) prog_len_q <= program_length_i;
      if (rf_we) rf_vld_q[dst_reg_q] <= 1'b1;
    end
  end

  // register file and item capture
  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[dst_reg_q] <= rf_wdata;
    if (in_fire) begin
      src_rd_q     <= rf_vld_q[src_reg_i] ? rf_mem[src_reg_i] : '0;
      dst_rd_q     <= rf_vld_q[dst_reg_i] ? rf_mem[dst_reg_i] : '0;
      act_q        <= action_e'(action_i);
      src_is_imm_q <= src_is_imm_i;
      src_imm_q    <= src_imm_i;
      dst_is_imm_q <= dst_is_imm_i;
      dst_reg_q    <= dst_reg_i;
      dst_imm_q    <= dst_imm_i;
      tgt_q        <= jump_target_i;
      rd_val_q     <= read_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    cnt_q  <= cnt_d;
    nip_q  <= nip_d;
    hlt_q  <= hlt_d;
    pv_q   <= pv_d;
    pval_q <= pval_d;
    dz_q   <= dz_d;
  end

  assign next_ip_o     = nip_q;
  assign halted_o      = hlt_q;
  assign print_valid_o = pv_q;
  assign print_value_o = pval_q;
  assign div_zero_o    = dz_q;

endmodule

// File: rtl/fri_checker.sv
// ----------------------------------------------------------------------------
// fri_checker
// port level checks for the four register interpreter core
// ----------------------------------------------------------------------------
module fri_checker
  import fri_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [IP_W-1:0]          next_ip_o,
  input logic                     halted_o,
  input logic                     print_valid_o,
  input logic signed [DATA_W-1:0] print_value_o,
  input logic                     div_zero_o
);

  // one item in flight at a time
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a result is pending");

  // after an accepted item the core is neither ready nor showing a result
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("item accepted without a working cycle");

  a_print_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !print_valid_o |-> print_value_o == '0)
    else $error("print value not zero without print");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_ip_o)
      && $stable(halted_o) && $stable(print_valid_o) && $stable(print_value_o)
      && $stable(div_zero_o))
    else $error("result changed while stalled");

endmodule

bind four_register_interpreter_core fri_checker u_fri_checker (.*);

// File: tb/four_register_interpreter_core_test.sv
// ----------------------------------------------------------------------------
// four_register_interpreter_core_test
// self-checking bench for the four register interpreter core: a directed
// pass over every operation and corner case, random programs at several
// program lengths, back-pressure and pauses, and a final halt that must
// stick; each result is checked against a predictor of the core
// ----------------------------------------------------------------------------
module four_register_interpreter_core_test
  import fri_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 210;
  localparam int MAX_REPORTS    = 10;

  localparam logic [3:0] ACT_UNUSED = 4'd15;
  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_B = 2'd1;
  localparam logic [1:0] REG_C = 2'd2;
  localparam logic [1:0] REG_D = 2'd3;
  localparam logic       USE_REG = 1'b0;
  localparam logic       USE_IMM = 1'b1;

  typedef struct packed {
    logic [3:0]               action;
    logic                     src_is_imm;
    logic [1:0]               src_reg;
    logic signed [DATA_W-1:0] src_imm;
    logic                     dst_is_imm;
    logic [1:0]               dst_reg;
    logic signed [DATA_W-1:0] dst_imm;
    logic [IP_W-1:0]          jump_target;
    logic signed [DATA_W-1:0] read_value;
  } instr_t;

  typedef struct packed {
    logic [IP_W-1:0]          next_ip;
    logic                     halted;
    logic                     print_valid;
    logic signed [DATA_W-1:0] print_value;
    logic                     div_zero;
  } outcome_t;

  typedef struct packed {
    logic [3:0][DATA_W-1:0] regs;
    logic [IP_W-1:0]        ip;
    logic                   halt;
  } core_state_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [LEN_W-1:0]         program_length_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [3:0]               action_i = '0;
  logic                     src_is_imm_i = 1'b0;
  logic [1:0]               src_reg_i = '0;
  logic signed [DATA_W-1:0] src_imm_i = '0;
  logic                     dst_is_imm_i = 1'b0;
  logic [1:0]               dst_reg_i = '0;
  logic signed [DATA_W-1:0] dst_imm_i = '0;
  logic [IP_W-1:0]          jump_target_i = '0;
  logic signed [DATA_W-1:0] read_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [IP_W-1:0]          next_ip_o;
  logic                     halted_o;
  logic                     print_valid_o;
  logic signed [DATA_W-1:0] print_value_o;
  logic                     div_zero_o;

  core_state_t      model_state = '0;
  logic [LEN_W-1:0] model_len = '0;
  outcome_t         expected_results[$];
  int               error_count = 0;
  int               in_idle_pct = 33;
  int               out_idle_pct = 33;
  int               holds_requested = 0;
  int               holds_granted = 0;
  int               hold_left = 0;
  int               quiet_cycles = 0;
  outcome_t         got_result;
  outcome_t         want_result;

  four_register_interpreter_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .program_length_i (program_length_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .src_is_imm_i     (src_is_imm_i),
    .src_reg_i        (src_reg_i),
    .src_imm_i        (src_imm_i),
    .dst_is_imm_i     (dst_is_imm_i),
    .dst_reg_i        (dst_reg_i),
    .dst_imm_i        (dst_imm_i),
    .jump_target_i    (jump_target_i),
    .read_value_i     (read_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .next_ip_o        (next_ip_o),
    .halted_o         (halted_o),
    .print_valid_o    (print_valid_o),
    .print_value_o    (print_value_o),
    .div_zero_o       (div_zero_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // one instruction on the predicted core state
  function automatic void execute_instr(input core_state_t cur, input instr_t it,
                                        input logic [LEN_W-1:0] len,
                                        output core_state_t nxt, output outcome_t res);
    int   src;
    int   opnd2;
    int   dval;
    int   wide;
    int   next_ip;
    logic taken;
    nxt   = cur;
    res   = '0;
    taken = 1'b0;
    wide  = 0;
    if (cur.halt || int'(cur.ip) >= int'(len) || int'(cur.ip) >= PROGRAM_DEPTH) begin
      nxt.halt    = 1'b1;
      res.next_ip = cur.ip;
      res.halted  = 1'b1;
      return;
    end
    src   = it.src_is_imm ? int'($signed(it.src_imm)) : int'($signed(cur.regs[it.src_reg]));
    dval  = int'($signed(cur.regs[it.dst_reg]));
    opnd2 = it.dst_is_imm ? int'($signed(it.dst_imm)) : dval;
    case (it.action)
      ACT_MOV: nxt.regs[it.dst_reg] = src[DATA_W-1:0];
      ACT_ADD: begin
        wide = dval + src;
        nxt.regs[it.dst_reg] = wide[DATA_W-1:0];
      end
      ACT_SUB: begin
        wide = dval - src;
        nxt.regs[it.dst_reg] = wide[DATA_W-1:0];
      end
      ACT_MUL: begin
        wide = dval * src;
        nxt.regs[it.dst_reg] = wide[DATA_W-1:0];
      end
      ACT_DIV: begin
        if (dval == 0) begin
          nxt.regs[it.dst_reg] = '0;
          res.div_zero = 1'b1;
        end else begin
          wide = src / dval;
          nxt.regs[it.dst_reg] = wide[DATA_W-1:0];
        end
      end
      ACT_JMP: taken = 1'b1;
      ACT_JE:  taken = (src == opnd2);
      ACT_JNE: taken = (src != opnd2);
      ACT_JG:  taken = (src > opnd2);
      ACT_JGE: taken = (src >= opnd2);
      ACT_JL:  taken = (src < opnd2);
      ACT_JLE: taken = (src <= opnd2);
      ACT_READ: nxt.regs[it.dst_reg] = it.read_value;
      ACT_PRINT: begin
        res.print_valid = 1'b1;
        res.print_value = src[DATA_W-1:0];
      end
      default: ;
    endcase
    next_ip = taken ? int'(it.jump_target) : int'(cur.ip) + 1;
    if (next_ip >= int'(len) || next_ip >= PROGRAM_DEPTH) nxt.halt = 1'b1;
    nxt.ip      = next_ip[IP_W-1:0];
    res.next_ip = next_ip[IP_W-1:0];
    res.halted  = nxt.halt;
  endfunction

  function automatic instr_t op(input logic [3:0] act, input logic s_imm,
                                input logic [1:0] s_reg, input int s_val,
                                input logic d_imm, input logic [1:0] d_reg,
                                input int d_val, input int tgt, input int rd);
    instr_t it;
    it.action      = act;
    it.src_is_imm  = s_imm;
    it.src_reg     = s_reg;
    it.src_imm     = s_val[DATA_W-1:0];
    it.dst_is_imm  = d_imm;
    it.dst_reg     = d_reg;
    it.dst_imm     = d_val[DATA_W-1:0];
    it.jump_target = tgt[IP_W-1:0];
    it.read_value  = rd[DATA_W-1:0];
    return it;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      4: return 16'sh0001;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic instr_t random_fields();
    instr_t it;
    it.action      = 4'($urandom_range(15));
    it.src_is_imm  = 1'($urandom_range(1));
    it.src_reg     = 2'($urandom_range(3));
    it.src_imm     = pick_value();
    it.dst_is_imm  = 1'($urandom_range(1));
    it.dst_reg     = 2'($urandom_range(3));
    it.dst_imm     = pick_value();
    it.read_value  = pick_value();
    if (model_len != 0 && $urandom_range(9) != 0)
      it.jump_target = 7'($urandom_range(int'(model_len) - 1));
    else
      it.jump_target = 7'($urandom_range(127));
    return it;
  endfunction

  // random instruction that keeps the program running
  function automatic instr_t random_instr();
    instr_t      it;
    core_state_t after;
    outcome_t    res;
    it = random_fields();
    execute_instr(model_state, it, model_len, after, res);
    if (after.halt) begin
      it.action      = ACT_JMP;
      it.jump_target = 7'($urandom_range(int'(model_len) - 1));
    end
    return it;
  endfunction

  function automatic string show(input outcome_t r);
    return $sformatf("ip=%0d halted=%0b print=%0b/%0d div_zero=%0b",
                     r.next_ip, r.halted, r.print_valid, r.print_value, r.div_zero);
  endfunction

  task automatic note_failure(input string detail);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] error: %s", $realtime, detail);
  endtask

  task automatic send_instr(input instr_t it);
    core_state_t after;
    outcome_t    res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= it.action;
    src_is_imm_i  <= it.src_is_imm;
    src_reg_i     <= it.src_reg;
    src_imm_i     <= it.src_imm;
    dst_is_imm_i  <= it.dst_is_imm;
    dst_reg_i     <= it.dst_reg;
    dst_imm_i     <= it.dst_imm;
    jump_target_i <= it.jump_target;
    read_value_i  <= it.read_value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    execute_instr(model_state, it, model_len, after, res);
    model_state = after;
    expected_results.push_back(res);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_instr(random_instr());
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    wait_drained();
    cfg_valid_i      <= 1'b1;
    program_length_i <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    model_len = len;
  endtask

  // back to slot 0 so that any new length keeps the ip in range
  task automatic start_program(input logic [LEN_W-1:0] len);
    send_instr(op(ACT_JMP, USE_IMM, REG_A, 0, USE_IMM, REG_A, 0, 0, 0));
    write_length(len);
  endtask

  task automatic test_directed();
    write_length(8'd128);
    send_instr(op(ACT_MOV,   USE_IMM, REG_A, 32767,  USE_REG, REG_A, 0,      0,   0));
    send_instr(op(ACT_MOV,   USE_IMM, REG_A, -32768, USE_REG, REG_B, 0,      0,   0));
    send_instr(op(ACT_ADD,   USE_IMM, REG_A, 1,      USE_REG, REG_A, 0,      0,   0));
    send_instr(op(ACT_SUB,   USE_IMM, REG_A, 1,      USE_REG, REG_B, 0,      0,   0));
    send_instr(op(ACT_MOV,   USE_IMM, REG_A, 300,    USE_REG, REG_C, 0,      0,   0));
    send_instr(op(ACT_MUL,   USE_REG, REG_C, 0,      USE_REG, REG_C, 0,      0,   0));
    send_instr(op(ACT_READ,  USE_REG, REG_A, 0,      USE_REG, REG_D, 0,      0,   -32768));
    send_instr(op(ACT_READ,  USE_REG, REG_A, 0,      USE_REG, REG_C, 0,      0,   -1));
    // most negative over minus one wraps
    send_instr(op(ACT_DIV,   USE_IMM, REG_A, -32768, USE_REG, REG_C, 0,      0,   0));
    send_instr(op(ACT_READ,  USE_REG, REG_A, 0,      USE_REG, REG_A, 0,      0,   0));
    // divide by zero
    send_instr(op(ACT_DIV,   USE_IMM, REG_A, 7,      USE_REG, REG_A, 0,      0,   0));
    send_instr(op(ACT_READ,  USE_REG, REG_A, 0,      USE_REG, REG_B, 0,      0,   2));
    send_instr(op(ACT_DIV,   USE_IMM, REG_A, -7,     USE_REG, REG_B, 0,      0,   0));
    send_instr(op(ACT_READ,  USE_REG, REG_A, 0,      USE_REG, REG_D, 0,      0,   32767));
    send_instr(op(ACT_DIV,   USE_REG, REG_C, 0,      USE_REG, REG_D, 0,      0,   0));
    send_instr(op(ACT_JMP,   USE_IMM, REG_A, 0,      USE_IMM, REG_A, 0,      20,  0));
    send_instr(op(ACT_JE,    USE_IMM, REG_A, 5,      USE_IMM, REG_A, 5,      30,  0));
    send_instr(op(ACT_JNE,   USE_REG, REG_D, 0,      USE_REG, REG_D, 0,      100, 0));
    send_instr(op(ACT_JG,    USE_REG, REG_B, 0,      USE_IMM, REG_A, -32768, 40,  0));
    send_instr(op(ACT_JGE,   USE_IMM, REG_A, -3,     USE_REG, REG_B, 0,      50,  0));
    send_instr(op(ACT_JL,    USE_IMM, REG_A, 32767,  USE_IMM, REG_A, -1,     90,  0));
    send_instr(op(ACT_JLE,   USE_REG, REG_C, 0,      USE_IMM, REG_A, 32767,  60,  0));
    send_instr(op(ACT_PRINT, USE_REG, REG_D, 0,      USE_REG, REG_A, 0,      0,   0));
    send_instr(op(ACT_PRINT, USE_IMM, REG_A, -32768, USE_REG, REG_A, 0,      0,   0));
    send_instr(op(ACT_NOP,   USE_IMM, REG_B, 1,      USE_IMM, REG_C, 1,      5,   9));
    send_instr(op(ACT_UNUSED, USE_IMM, REG_B, 1,     USE_IMM, REG_C, 1,      5,   9));
  endtask

  task automatic test_random_programs();
    logic [LEN_W-1:0] lengths[6];
    lengths = '{8'd1, 8'd2, 8'd9, 8'd64, 8'd127, 8'd128};
    foreach (lengths[i]) begin
      start_program(lengths[i]);
      send_random(PHASE_ITEMS);
    end
  endtask

  task automatic test_streaming();
    start_program(8'd128);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_random(200);
    wait_drained();
    in_idle_pct  = 33;
    out_idle_pct = 33;
  endtask

  task automatic test_output_stall();
    start_program(8'd128);
    holds_requested++;
    send_random(40);
  endtask

  task automatic test_sender_pause();
    repeat (6) begin
      send_random(10);
      wait_drained();
    end
  endtask

  // fall-through past the last slot halts for good
  task automatic test_halt();
    start_program(8'd128);
    send_instr(op(ACT_JMP, USE_IMM, REG_A, 0, USE_IMM, REG_A, 0, 127, 0));
    send_instr(op(ACT_MOV, USE_IMM, REG_A, 1, USE_REG, REG_A, 0, 0,   0));
    repeat (4) send_instr(random_fields());
    write_length(8'd0);
    repeat (3) send_instr(random_fields());
    write_length(8'd77);
    repeat (3) send_instr(random_fields());
  endtask

  // receiver: random ready, long hold-off on request
  always @(posedge clk_i) begin
    if (holds_granted != holds_requested) begin
      holds_granted++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_result = {next_ip_o, halted_o, print_valid_o, print_value_o, div_zero_o};
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result %s", show(got_result)));
      end else begin
        want_result = expected_results.pop_front();
        if (got_result !== want_result)
          note_failure($sformatf("expected %s, got %s", show(want_result), show(got_result)));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_programs();
    test_streaming();
    test_output_stall();
    test_sender_pause();
    test_halt();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
